>>> rtl/bfx_pkg.sv
package bfx_pkg;

  localparam int unsigned ProgDepthDefault    = 4096;
  localparam int unsigned TapeDepthDefault    = 32768;
  localparam int unsigned BracketDepthDefault = 256;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_RIGHT = 4'd1,
    OP_LEFT  = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_OUT   = 4'd5,
    OP_IN    = 4'd6,
    OP_OPEN  = 4'd7,
    OP_CLOSE = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNMATCH = 2'd1,
    ST_FULL   = 2'd2,
    ST_LATE   = 2'd3
  } status_e;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
    logic       needs_input;
    logic [1:0] status;
  } result_t;

  function automatic op_e decode_char(input logic [7:0] ch);
    op_e op;
    op = OP_NONE;
    case (ch)
      8'h3E:   op = OP_RIGHT;
      8'h3C:   op = OP_LEFT;
      8'h2B:   op = OP_INC;
      8'h2D:   op = OP_DEC;
      8'h2E:   op = OP_OUT;
      8'h2C:   op = OP_IN;
      8'h5B:   op = OP_OPEN;
      8'h5D:   op = OP_CLOSE;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

>>> rtl/brainfuck_execution_core.sv
// Channel | Direction | Beat contents
// in      | input     | kind_i, source_char_i, in_byte_i (valid_i / ready_o)
// out     | output    | out_valid_o, out_byte_o, halted_o, needs_input_o, status_o
//                       (valid_o / ready_i)
//
// A beat passes through S_IDLE, in which it is accepted, then S_READ to read the
// program entry, tape cell and bracket top, S_EXEC for the read-modify-write of
// the program store, tape and bracket stack, S_FETCH to read the program entry
// at the new program counter, and S_DONE to form the result. The memories have
// registered reads, and the result shows on valid_o once it leaves S_DONE.
// After reset the tape is swept to zero, one cell per cycle, before the first
// beat is accepted. The result sits in an output register; a finished beat
// leaves its last cycle only when that register is free or being taken, so the
// input stalls while a result waits.
module brainfuck_execution_core #(
  parameter int unsigned ProgDepth    = bfx_pkg::ProgDepthDefault,
  parameter int unsigned TapeDepth    = bfx_pkg::TapeDepthDefault,
  parameter int unsigned BracketDepth = bfx_pkg::BracketDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic       kind_i,
  input  logic [7:0] source_char_i,
  input  logic [7:0] in_byte_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       halted_o,
  output logic       needs_input_o,
  output logic [1:0] status_o
);
  import bfx_pkg::*;

  localparam int unsigned PW = $clog2(ProgDepth);
  localparam int unsigned TW = $clog2(TapeDepth);
  localparam int unsigned BW = $clog2(BracketDepth);
  localparam int unsigned LW = PW + 1;
  localparam int unsigned SW = BW + 1;
  localparam int unsigned AW = (PW > 8) ? PW : 8;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_FETCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Memories: program store holds opcode and argument, tape holds cells.
  logic [3:0]    pop_mem [ProgDepth];
  logic [AW-1:0] parg_mem [ProgDepth];
  logic [7:0]    tape_mem [TapeDepth];
  logic [PW-1:0] bstk_mem [BracketDepth];

  logic [LW-1:0] plen_q;
  logic [3:0]    last_op_q;
  logic [7:0]    last_rep_q;
  logic [SW-1:0] stop_q;
  logic [LW-1:0] pc_q;
  logic [TW-1:0] dp_q;
  logic          started_q;
  logic [1:0]    err_q;
  logic [TW-1:0] clr_q;

  logic          kind_q;
  logic [7:0]    ch_q, ib_q;
  logic          late_q;

  logic [3:0]    rd_op_q;
  logic [AW-1:0] rd_arg_q;
  logic [7:0]    rd_cell_q;
  logic [PW-1:0] rd_bstk_q;
  logic          ov_q;
  logic [7:0]    ob_q;

  result_t res_q;
  logic    res_vld_q;

  logic accept;
  assign ready_o = (state_q == S_IDLE);
  assign accept  = valid_i && ready_o;

  // Address sources for the shared memory ports.
  logic [PW-1:0] prd_addr;
  logic [PW-1:0] pc_idx;
  assign pc_idx = pc_q[PW-1:0];
  always_comb begin
    prd_addr = pc_idx;
    if (state_q == S_FETCH) prd_addr = pc_idx;
  end

  // Load decode.
  op_e  ld_op;
  logic ld_rep, ld_merge;
  assign ld_op    = decode_char(ch_q);
  assign ld_rep   = (ld_op == OP_RIGHT) || (ld_op == OP_LEFT) ||
                    (ld_op == OP_INC) || (ld_op == OP_DEC);
  assign ld_merge = ld_rep && (last_op_q == ld_op) && (last_rep_q != 8'hFF) &&
                    (plen_q != '0);

  logic [LW-1:0] plen_m1;
  assign plen_m1 = plen_q - LW'(1);

  // Execute conditions.
  logic ex_first_err, ex_run, ex_out;
  assign ex_first_err = !started_q && (err_q == ST_OK) && (stop_q != '0);
  assign ex_run = (err_q == ST_OK) && !ex_first_err && (pc_q < plen_q);
  assign ex_out = kind_q && ex_run && (rd_op_q == OP_OUT);

  logic [TW-1:0] arg_t;
  assign arg_t = TW'(rd_arg_q);

  // Memory write controls.
  logic          pw_op_en, pw_arg_en, pw_arg2_en;
  logic [PW-1:0] pw_addr, pw_addr2;
  logic [3:0]    pw_op;
  logic [AW-1:0] pw_arg, pw_arg2;
  logic          tw_en;
  logic [TW-1:0] tw_addr;
  logic [7:0]    tw_data;
  logic          bw_en;

  always_comb begin
    pw_op_en   = 1'b0;
    pw_arg_en  = 1'b0;
    pw_arg2_en = 1'b0;
    pw_addr    = plen_q[PW-1:0];
    pw_addr2   = rd_bstk_q;
    pw_op      = ld_op;
    pw_arg     = AW'(1);
    pw_arg2    = AW'(plen_q[PW-1:0]);
    tw_en      = 1'b0;
    tw_addr    = dp_q;
    tw_data    = rd_cell_q;
    bw_en      = 1'b0;
    if (state_q == S_CLEAR) begin
      tw_en   = 1'b1;
      tw_addr = clr_q;
      tw_data = 8'd0;
    end else if (state_q == S_EXEC) begin
      if (!kind_q) begin
        if (!late_q && err_q == ST_OK && ld_op != OP_NONE) begin
          if (ld_merge) begin
            pw_arg_en = 1'b1;
            pw_addr   = plen_m1[PW-1:0];
            pw_arg    = AW'(last_rep_q) + AW'(1);
          end else if (plen_q < LW'(ProgDepth)) begin
            if (ld_op == OP_OPEN) begin
              if (stop_q < SW'(BracketDepth)) begin
                pw_op_en  = 1'b1;
                pw_arg_en = 1'b1;
                pw_arg    = '0;
                bw_en     = 1'b1;
              end
            end else if (ld_op == OP_CLOSE) begin
              if (stop_q != '0) begin
                pw_op_en   = 1'b1;
                pw_arg_en  = 1'b1;
                pw_arg     = AW'(rd_bstk_q);
                pw_arg2_en = 1'b1;
              end
            end else begin
              pw_op_en  = 1'b1;
              pw_arg_en = 1'b1;
            end
          end
        end
      end else if (ex_run) begin
        case (rd_op_q)
          OP_INC: begin
            tw_en   = 1'b1;
            tw_data = rd_cell_q + rd_arg_q[7:0];
          end
          OP_DEC: begin
            tw_en   = 1'b1;
            tw_data = rd_cell_q - rd_arg_q[7:0];
          end
          OP_IN: begin
            tw_en   = 1'b1;
            tw_data = ib_q;
          end
          default: tw_en = 1'b0;
        endcase
      end
    end
  end

  // The second argument write (back-patching an open bracket) happens in the
  // following cycle, in S_FETCH, through the same write port.
  logic          patch_q;
  logic [PW-1:0] patch_addr_q;
  logic [AW-1:0] patch_arg_q;

  always_ff @(posedge clk_i) begin
    if (pw_op_en) pop_mem[pw_addr] <= pw_op;
    if (pw_arg_en) begin
      parg_mem[pw_addr] <= pw_arg;
    end else if (patch_q) begin
      parg_mem[patch_addr_q] <= patch_arg_q;
    end
    rd_op_q  <= pop_mem[prd_addr];
    rd_arg_q <= parg_mem[prd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tw_en) tape_mem[tw_addr] <= tw_data;
    rd_cell_q <= tape_mem[dp_q];
  end

  always_ff @(posedge clk_i) begin
    if (bw_en) bstk_mem[stop_q[BW-1:0]] <= plen_q[PW-1:0];
    rd_bstk_q <= bstk_mem[BW'(stop_q - SW'(1))];
  end

  always_ff @(posedge clk_i) begin
    patch_q      <= pw_arg2_en;
    patch_addr_q <= pw_addr2;
    patch_arg_q  <= pw_arg2;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == TW'(TapeDepth - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC:  state_d = S_FETCH;
      S_FETCH: state_d = S_DONE;
      S_DONE:  if (!res_vld_q || ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [LW-1:0] next_pc;
  always_comb begin
    next_pc = pc_q + LW'(1);
    if (rd_op_q == OP_OPEN && rd_cell_q == 8'd0) next_pc = LW'(rd_arg_q) + LW'(1);
    if (rd_op_q == OP_CLOSE && rd_cell_q != 8'd0) next_pc = LW'(rd_arg_q) + LW'(1);
  end

  logic halted_w;
  assign halted_w = (pc_q >= plen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      plen_q    <= '0;
      last_op_q <= OP_NONE;
      last_rep_q <= '0;
      stop_q    <= '0;
      pc_q      <= '0;
      dp_q      <= '0;
      started_q <= 1'b0;
      err_q     <= ST_OK;
      res_vld_q <= 1'b0;
      kind_q    <= 1'b0;
      ch_q      <= 8'd0;
      ib_q      <= 8'd0;
      late_q    <= 1'b0;
      ov_q      <= 1'b0;
      ob_q      <= 8'd0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + TW'(1);
      if (state_q == S_DONE && (!res_vld_q || ready_i)) begin
        res_vld_q <= 1'b1;
      end else if (res_vld_q && ready_i) begin
        res_vld_q <= 1'b0;
      end
      if (accept) begin
        kind_q <= kind_i;
        ch_q   <= source_char_i;
        ib_q   <= in_byte_i;
        late_q <= !kind_i && started_q;
      end
      if (state_q == S_EXEC) begin
        ov_q <= ex_out;
        ob_q <= ex_out ? rd_cell_q : 8'd0;
        if (!kind_q) begin
          if (!late_q && err_q == ST_OK) begin
            if (ld_op == OP_NONE) begin
              last_op_q  <= OP_NONE;
              last_rep_q <= '0;
            end else if (ld_merge) begin
              last_rep_q <= last_rep_q + 8'd1;
            end else if (plen_q >= LW'(ProgDepth)) begin
              err_q <= ST_FULL;
            end else if (ld_op == OP_OPEN && stop_q >= SW'(BracketDepth)) begin
              err_q <= ST_UNMATCH;
            end else if (ld_op == OP_CLOSE && stop_q == '0) begin
              err_q <= ST_UNMATCH;
            end else begin
              if (ld_op == OP_OPEN) stop_q <= stop_q + SW'(1);
              if (ld_op == OP_CLOSE) stop_q <= stop_q - SW'(1);
              plen_q     <= plen_q + LW'(1);
              last_op_q  <= ld_rep ? ld_op : OP_NONE;
              last_rep_q <= ld_rep ? 8'd1 : 8'd0;
            end
          end
        end else begin
          started_q <= 1'b1;
          if (ex_first_err) err_q <= ST_UNMATCH;
          if (ex_run) begin
            pc_q <= next_pc;
            case (rd_op_q)
              OP_RIGHT: dp_q <= dp_q + arg_t;
              OP_LEFT:  dp_q <= dp_q - arg_t;
              default:  dp_q <= dp_q;
            endcase
          end
        end
      end
    end
  end

  // The program store read in S_FETCH registers the opcode at the new pc, seen here in S_DONE.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!res_vld_q || ready_i)) begin
      res_q.out_valid   <= ov_q;
      res_q.out_byte    <= ob_q;
      res_q.halted      <= halted_w;
      res_q.needs_input <= !halted_w && (err_q == ST_OK) && (rd_op_q == OP_IN);
      res_q.status      <= late_q ? ST_LATE : err_q;
    end
  end

  assign valid_o       = res_vld_q;
  assign out_valid_o   = res_q.out_valid;
  assign out_byte_o    = res_q.out_byte;
  assign halted_o      = res_q.halted;
  assign needs_input_o = res_q.needs_input;
  assign status_o      = res_q.status;

  unused_nx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !ready_o)
    else $error("beat taken during tape clear");
  a_lenbound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= LW'(ProgDepth))
    else $error("program length overflow");
  a_stack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q <= SW'(BracketDepth))
    else $error("bracket stack overflow");
  a_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK) |=> (err_q == $past(err_q)))
    else $error("latched error changed");

endmodule
